/* rtl/vic_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vic_pkg;

    // Field width of the request and result indices, and width of the next-compact counter.
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    // Width of the mesh tag kept with each table entry.
    localparam int EPOCH_W = 12;

    // Saturation value of the next-compact counter.
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(4096);

    typedef struct packed {
        logic [IDX_W-1:0] pool_index;
        logic             end_of_mesh;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] compact_index;
        logic             first_seen;
        logic [IDX_W-1:0] source_index;
        logic             last_of_mesh;
    } t_out_item;

    // One remap table entry: the mesh tag it was written in and its compact index.
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [IDX_W-1:0]   compact;
    } t_slot;

endpackage

`default_nettype wire

/* rtl/vic_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface vic_in_if;
    logic               valid;
    logic               ready;
    vic_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vic_out_if;
    logic               valid;
    logic               ready;
    vic_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/vertex_index_compaction.sv */
`timescale 1ns / 1ps
`default_nettype none
// A request passes through stage 1, where its table entry is read, and then the output register.
// Throughput: one request per cycle, set by the single table read-modify-write per request, while
// no sweep runs and the output is not stalled. Reset and every 4095th mesh end start a tag clearing
// sweep through all min(POOL_DEPTH, 4096) remap table entries, during which no request is accepted;
// at such a mesh end the input also waits while the final request is in the lookup stage.
// Reset is synchronous and active low; it clears control state and starts that sweep.

module vertex_index_compaction #(
    parameter int POOL_DEPTH = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vic_in_if.sink     i_in,
    vic_out_if.source  o_out
);
    import vic_pkg::*;

    // The table only needs entries for indices that the 12-bit field can reach.
    localparam int MEM_DEPTH = (POOL_DEPTH < 4096) ? POOL_DEPTH : 4096;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Remap table. Each entry carries the tag of the mesh that wrote it, so an
    // entry counts as valid only when its tag equals the current mesh tag. This
    // replaces a per-mesh clear of all valid marks. The tag wraps after many
    // meshes, and then a sweep rewrites every entry with tag zero, which is
    // never a live tag.
    t_slot mem [MEM_DEPTH];

    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [EPOCH_W-1:0] r_epoch;
    logic [CNT_W-1:0]   r_next;

    // Stage 1: the request whose table entry was read as it was accepted.
    logic               r_s1_valid;
    logic [IDX_W-1:0]   r_s1_idx;
    logic               r_s1_last;
    logic               r_s1_inr;
    t_slot              r_rd_data;

    // Forwarding of a write that happened at the same edge as the read.
    logic               r_fwd_hit;
    t_slot              r_fwd_data;

    // Output register.
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               s1_adv;
    logic               in_accept;
    logic               in_range;
    logic               epoch_wrap;
    t_slot              rd_slot;
    logic               hit;
    logic               fresh;
    logic [IDX_W-1:0]   compact;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    t_slot              wr_data;
    logic [ADDR_W-1:0]  rd_addr;

    // Stage 1 moves on when the output register is empty or being emptied.
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    // A final request in the last tag of the cycle starts a sweep, so nothing
    // may be read from the table alongside it.
    assign epoch_wrap = (r_epoch == {EPOCH_W{1'b1}});

    assign i_in.ready = !r_clearing
                        && !(r_s1_valid && r_s1_last && epoch_wrap)
                        && (!r_s1_valid || s1_adv);
    assign in_accept  = i_in.valid && i_in.ready;

    assign in_range   = (32'(i_in.data.pool_index) < 32'(POOL_DEPTH));
    assign rd_addr    = i_in.data.pool_index[ADDR_W-1:0];

    // Lookup: the forwarded entry wins over the memory data when the previous
    // request wrote the same entry at the edge this one was read.
    always_comb begin
        rd_slot = r_fwd_hit ? r_fwd_data : r_rd_data;
        hit     = r_s1_inr && (rd_slot.tag == r_epoch);
        fresh   = r_s1_inr && !hit;
        if (!r_s1_inr) begin
            compact = '0;
        end else if (hit) begin
            compact = rd_slot.compact;
        end else begin
            compact = r_next[IDX_W-1:0];
        end
    end

    // One write port, shared by the sweep and the allocation of new entries.
    always_comb begin
        if (r_clearing) begin
            wr_en           = 1'b1;
            wr_addr         = r_clr_addr;
            wr_data.tag     = '0;
            wr_data.compact = '0;
        end else begin
            wr_en           = s1_adv && fresh;
            wr_addr         = r_s1_idx[ADDR_W-1:0];
            wr_data.tag     = r_epoch;
            wr_data.compact = r_next[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_idx   <= i_in.data.pool_index;
            r_s1_last  <= i_in.data.end_of_mesh;
            r_s1_inr   <= in_range;
            r_fwd_data <= wr_data;
        end
        if (s1_adv) begin
            r_out_data.compact_index <= compact;
            r_out_data.first_seen    <= fresh;
            r_out_data.source_index  <= r_s1_idx;
            r_out_data.last_of_mesh  <= r_s1_last;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_epoch     <= EPOCH_W'(1);
            r_next      <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end

            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= wr_en && (wr_addr == rd_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
                if (r_s1_last) begin
                    // The mesh ends: move to a fresh tag and restart numbering.
                    r_next <= '0;
                    if (epoch_wrap) begin
                        r_epoch    <= EPOCH_W'(1);
                        r_clearing <= 1'b1;
                        r_clr_addr <= '0;
                    end else begin
                        r_epoch <= r_epoch + 1'b1;
                    end
                end else if (fresh && (r_next < CNT_LIMIT)) begin
                    r_next <= r_next + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

`default_nettype wire
